FILE: sv/accel_tilt_roll_pitch_assert.svh
// Assertion macros shared by the tilt-angle block.
`ifndef ACCEL_TILT_ROLL_PITCH_ASSERT_SVH
`define ACCEL_TILT_ROLL_PITCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ATRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atrp assertion failed");

// Next-cycle implication, checked outside reset.
`define ATRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atrp assertion failed");

`endif

FILE: sv/atrp_pkg.sv
// ----------------------------------------------------------------------------
// atrp_pkg
// Constants, types and the arctangent table of the tilt-angle block.
// ----------------------------------------------------------------------------
package atrp_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int TAB_LEN         = 24;
  localparam int ACC_FRAC        = 20;
  localparam int CORDIC_N = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

  localparam int ACCEL_W = 16;
  localparam int ANGLE_W = 16;
  localparam int SQ_W    = 32;            // a^2 + b^2
  localparam int RAD_W   = SQ_W + 16;     // radicand, 8 fraction bits in the root
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int XY_W    = 28;
  localparam int Z_W     = 29;
  localparam int SQRT_N  = ROOT_W;
  localparam int LAT     = SQRT_N + CORDIC_N;
  localparam int RND_SH  = ACC_FRAC - ANGLE_FRAC_BITS;

  typedef struct packed {
    logic [SQ_W-1:0]           sq_roll;
    logic [SQ_W-1:0]           sq_pitch;
    logic signed [ACCEL_W-1:0] num_roll;
    logic signed [ACCEL_W-1:0] num_pitch;
  } atrp_item_t;

  // round(atan(2^-i) * 2^20) in degrees
  function automatic logic [Z_W-1:0] atan_entry(input int unsigned i);
    unique case (i)
      0:  return Z_W'(47185920);
      1:  return Z_W'(27855475);
      2:  return Z_W'(14718068);
      3:  return Z_W'(7471121);
      4:  return Z_W'(3750058);
      5:  return Z_W'(1876857);
      6:  return Z_W'(938658);
      7:  return Z_W'(469357);
      8:  return Z_W'(234682);
      9:  return Z_W'(117342);
      10: return Z_W'(58671);
      11: return Z_W'(29335);
      12: return Z_W'(14668);
      13: return Z_W'(7334);
      14: return Z_W'(3667);
      15: return Z_W'(1833);
      16: return Z_W'(917);
      17: return Z_W'(458);
      18: return Z_W'(229);
      19: return Z_W'(115);
      20: return Z_W'(57);
      21: return Z_W'(29);
      22: return Z_W'(14);
      23: return Z_W'(7);
      default: return '0;
    endcase
  endfunction

endpackage

FILE: sv/atrp_if.sv
// ----------------------------------------------------------------------------
// atrp_in_if / atrp_out_if
// Valid/ready channels for samples and angle results.
// ----------------------------------------------------------------------------
interface atrp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [atrp_pkg::ACCEL_W-1:0]    accel_x;
  logic signed [atrp_pkg::ACCEL_W-1:0]    accel_y;
  logic signed [atrp_pkg::ACCEL_W-1:0]    accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atrp_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [atrp_pkg::ANGLE_W-1:0]    roll_angle;
  logic signed [atrp_pkg::ANGLE_W-1:0]    pitch_angle;
  modport source (output valid, roll_angle, pitch_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, output ready);
endinterface

FILE: sv/atrp_front.sv
// ----------------------------------------------------------------------------
// atrp_front
// Takes a sample, forms the two sums of squares and the two numerators.
// ----------------------------------------------------------------------------
module atrp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_x,
  input  logic signed [15:0]   in_y,
  input  logic signed [15:0]   in_z,
  output logic                 push_valid,
  input  logic                 push_ready,
  output atrp_pkg::atrp_item_t push_item
);
  import atrp_pkg::*;

  logic       valid_r, valid_nxt;
  atrp_item_t item_r, item_nxt;
  logic signed [SQ_W-1:0] xx, yy, zz;

  assign xx = SQ_W'(in_x * in_x);
  assign yy = SQ_W'(in_y * in_y);
  assign zz = SQ_W'(in_z * in_z);

  assign in_ready = !valid_r || push_ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      item_nxt.sq_roll   = $unsigned(xx) + $unsigned(zz);
      item_nxt.sq_pitch  = $unsigned(yy) + $unsigned(zz);
      item_nxt.num_roll  = in_y;
      item_nxt.num_pitch = in_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;
endmodule

FILE: sv/atrp_fifo.sv
// ----------------------------------------------------------------------------
// atrp_fifo
// Two-entry queue between the front stage and the angle pipeline.
// ----------------------------------------------------------------------------
module atrp_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  atrp_pkg::atrp_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output atrp_pkg::atrp_item_t pop_item
);
  import atrp_pkg::*;
  `include "accel_tilt_roll_pitch_assert.svh"

  atrp_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `ATRP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r != 2'd3)
  `ATRP_ASSERT_NOW(a_ptr_match, (cnt_r == 2'd0) || (cnt_r == 2'd2), wr_ptr_r == rd_ptr_r)
  `ATRP_ASSERT_NEXT(a_pop_only, pop && !push, cnt_r == $past(cnt_r) - 2'd1)
endmodule

FILE: sv/atrp_lane.sv
// ----------------------------------------------------------------------------
// atrp_lane
// One angle: pipelined bit-per-stage square root, then CORDIC vectoring.
// ----------------------------------------------------------------------------
module atrp_lane (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         sq,
  input  logic signed [15:0]  num,
  output logic signed [15:0]  angle
);
  import atrp_pkg::*;

  logic [REM_W-1:0]          rem_r  [SQRT_N];
  logic [ROOT_W-1:0]         root_r [SQRT_N];
  logic [RAD_W-1:0]          rad_r  [SQRT_N];
  logic signed [ACCEL_W-1:0] num_r  [SQRT_N];
  logic                      zq_r   [SQRT_N];

  logic signed [XY_W-1:0]    cx_r [CORDIC_N];
  logic signed [XY_W-1:0]    cy_r [CORDIC_N];
  logic signed [Z_W-1:0]     cz_r [CORDIC_N];
  logic                      cq_r [CORDIC_N];

  for (genvar s = 0; s < SQRT_N; s++) begin : g_sqrt
    logic [REM_W-1:0]          rem_in, rem_sh, trial;
    logic [ROOT_W-1:0]         root_in;
    logic [RAD_W-1:0]          rad_in;
    logic signed [ACCEL_W-1:0] num_in;
    logic                      zq_in, ge;
    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {sq, 16'h0000};
      assign num_in  = num;
      assign zq_in   = (sq == '0) && (num == '0);
    end else begin : g_rest
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign rad_in  = rad_r[s-1];
      assign num_in  = num_r[s-1];
      assign zq_in   = zq_r[s-1];
    end
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? rem_sh - trial : rem_sh;
        root_r[s] <= {root_in[ROOT_W-2:0], ge};
        rad_r[s]  <= rad_in << 2;
        num_r[s]  <= num_in;
        zq_r[s]   <= zq_in;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
    logic signed [XY_W-1:0] x_in, y_in, xs, ys;
    logic signed [Z_W-1:0]  z_in, tab;
    logic                   q_in;
    if (i == 0) begin : g_first
      assign x_in = XY_W'(root_r[SQRT_N-1]);
      assign y_in = {{(XY_W-ACCEL_W-8){num_r[SQRT_N-1][ACCEL_W-1]}},
                     num_r[SQRT_N-1], 8'h00};
      assign z_in = '0;
      assign q_in = zq_r[SQRT_N-1];
    end else begin : g_rest
      assign x_in = cx_r[i-1];
      assign y_in = cy_r[i-1];
      assign z_in = cz_r[i-1];
      assign q_in = cq_r[i-1];
    end
    assign xs  = x_in >>> i;
    assign ys  = y_in >>> i;
    assign tab = $signed(atan_entry(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_in[XY_W-1]) begin
          cx_r[i] <= x_in + ys;
          cy_r[i] <= y_in - xs;
          cz_r[i] <= z_in + tab;
        end else begin
          cx_r[i] <= x_in - ys;
          cy_r[i] <= y_in + xs;
          cz_r[i] <= z_in - tab;
        end
        cq_r[i] <= q_in;
      end
    end
  end

  // Round to the output unit, clamp to a quarter turn, then to 16 bits.
  logic signed [31:0] zw, rnd, lim, clamped;
  assign zw  = 32'(cz_r[CORDIC_N-1]);
  assign rnd = (zw + (32'sd1 <<< (RND_SH - 1))) >>> RND_SH;
  assign lim = 32'sd90 <<< ANGLE_FRAC_BITS;

  always_comb begin
    clamped = rnd;
    if (clamped > lim)       clamped = lim;
    if (clamped < -lim)      clamped = -lim;
    if (clamped > 32'sd32767)  clamped = 32'sd32767;
    if (clamped < -32'sd32768) clamped = -32'sd32768;
  end

  assign angle = cq_r[CORDIC_N-1] ? '0 : clamped[ANGLE_W-1:0];
endmodule

FILE: sv/atrp_back.sv
// ----------------------------------------------------------------------------
// atrp_back
// Angle pipeline for roll and pitch with the result register.
// ----------------------------------------------------------------------------
module atrp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  atrp_pkg::atrp_item_t pop_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_roll,
  output logic signed [15:0]   out_pitch
);
  import atrp_pkg::*;

  logic                      en;
  logic [LAT-1:0]            v_r, v_nxt;
  logic                      ov_r, ov_nxt;
  logic signed [ANGLE_W-1:0] roll_r, pitch_r, roll_a, pitch_a;

  // The whole pipeline moves when the result register can take a new value.
  assign en        = !ov_r || out_ready;
  assign pop_ready = en;

  atrp_lane u_roll (
    .clk(clk), .en(en), .sq(pop_item.sq_roll), .num(pop_item.num_roll), .angle(roll_a)
  );
  atrp_lane u_pitch (
    .clk(clk), .en(en), .sq(pop_item.sq_pitch), .num(pop_item.num_pitch), .angle(pitch_a)
  );

  always_comb begin
    v_nxt  = v_r;
    ov_nxt = ov_r;
    if (en) begin
      v_nxt  = {v_r[LAT-2:0], pop_valid};
      ov_nxt = v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      v_r  <= v_nxt;
      ov_r <= ov_nxt;
    end
    if (en) begin
      roll_r  <= roll_a;
      pitch_r <= pitch_a;
    end
  end

  assign out_valid = ov_r;
  assign out_roll  = roll_r;
  assign out_pitch = pitch_r;
endmodule

FILE: sv/accel_tilt_roll_pitch.sv
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch
// Roll and pitch angles from one raw three-axis accelerometer sample.
// ----------------------------------------------------------------------------
// Accepts one sample per cycle while results are taken, and returns roll and pitch
// in 1/256 degree. The transfer loads the squares register, then the sample passes
// the two-entry queue, 24 square-root stages (one root bit each), 16 CORDIC stages
// and the result register. When the result is not taken, the whole angle pipeline
// holds and the queue absorbs two samples.
module accel_tilt_roll_pitch (
  input logic     clk,
  input logic     rst_n,
  atrp_in_if.sink   in_ch,
  atrp_out_if.source out_ch
);
  import atrp_pkg::*;

  logic       push_valid, push_ready, pop_valid, pop_ready;
  atrp_item_t push_item, pop_item;

  atrp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_x(in_ch.accel_x), .in_y(in_ch.accel_y), .in_z(in_ch.accel_z),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item)
  );

  atrp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item)
  );

  atrp_back u_back (
    .clk(clk), .rst_n(rst_n),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_roll(out_ch.roll_angle), .out_pitch(out_ch.pitch_angle)
  );
endmodule
